// ===== rtl/emfd_pkg.sv =====
// Package: shared types and constants for the energy meter frame decoder.
package emfd_pkg;
  localparam logic [7:0] HDR_BYTE = 8'h55;
  localparam logic [7:0] SUM_SEED = 8'h58;
  localparam logic [23:0] WRAP_HIGH = 24'hFF0000;
  localparam logic [23:0] WRAP_LOW = 24'h00FFFF;
  localparam logic [2:0] REG_VGAIN = 3'd0;
  localparam logic [2:0] REG_IGAIN = 3'd1;
  localparam logic [2:0] REG_PGAIN = 3'd2;

  typedef struct packed {
    logic        clr;
    logic [23:0] ia;
    logic [23:0] iv;
    logic [23:0] pw;
    logic [23:0] cnt;
  } frame_t;

  typedef struct packed {
    logic [15:0] volts;
    logic [15:0] amps;
    logic [14:0] watts;
    logic [31:0] energy_total;
    logic [23:0] raw_volts;
    logic [23:0] raw_amps;
    logic [23:0] raw_watts;
  } result_t;
endpackage

// ===== rtl/emfd_if.sv =====
// Interfaces: valid/ready channels for requests and results.
interface emfd_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;
  modport source (output valid, cmd, rx_byte, input ready);
  modport sink (input valid, cmd, rx_byte, output ready);
endinterface

interface emfd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] volts;
  logic [15:0] amps;
  logic [14:0] watts;
  logic [31:0] energy_total;
  logic [23:0] raw_volts;
  logic [23:0] raw_amps;
  logic [23:0] raw_watts;
  modport source (output valid, volts, amps, watts, energy_total, raw_volts, raw_amps,
    raw_watts, input ready);
  modport sink (input valid, volts, amps, watts, energy_total, raw_volts, raw_amps,
    raw_watts, output ready);
endinterface

// ===== rtl/emfd_front.sv =====
// Front end: byte window, header and checksum match, frame/clear extraction.
module emfd_front #(
  parameter int FRAME_BYTES = 23
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic [7:0]        rx_byte,
  output logic              fr_valid,
  input  logic              fr_ready,
  output emfd_pkg::frame_t  fr
);
  localparam int FW = $clog2(FRAME_BYTES + 1);
  localparam int IW = $clog2(FRAME_BYTES);

  logic [7:0]    win [FRAME_BYTES];
  logic [FW-1:0] fill;
  logic [7:0]    sum;          // running seed + bytes of window except last slot
  logic [7:0]    win_next [FRAME_BYTES];
  logic [FW-1:0] fill_next;
  logic [7:0]    sum_next;
  logic          take, hit;
  logic [7:0]    hsum;

  assign in_ready = !fr_valid || fr_ready;
  assign take = in_valid && in_ready;

  // Sum is maintained incrementally: seed plus bytes 0..fill-1 (capped at frame-1).
  always_comb begin
    hit = 1'b0;
    hsum = '0;
    for (int i = 0; i < FRAME_BYTES; i++) win_next[i] = win[i];
    fill_next = fill;
    sum_next = sum;
    if (take && !cmd) begin
      if (fill == FW'(FRAME_BYTES)) begin
        // drop oldest; window held FRAME_BYTES-1 in sum already minus nothing
        for (int i = 0; i < FRAME_BYTES - 1; i++) win_next[i] = win[i + 1];
        win_next[FRAME_BYTES - 1] = rx_byte;
        sum_next = sum - win[0] + win[FRAME_BYTES - 1];
      end else begin
        win_next[fill[IW-1:0]] = rx_byte;
        fill_next = fill + 1'b1;
        if (fill != FW'(FRAME_BYTES - 1)) sum_next = sum + rx_byte;
      end
      if (fill_next == FW'(FRAME_BYTES)) begin
        hsum = ~sum_next;
        if (win_next[0] == emfd_pkg::HDR_BYTE && hsum == win_next[FRAME_BYTES - 1]) begin
          hit = 1'b1;
          fill_next = '0;
          sum_next = emfd_pkg::SUM_SEED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      sum <= emfd_pkg::SUM_SEED;
      fr_valid <= 1'b0;
      for (int i = 0; i < FRAME_BYTES; i++) win[i] <= '0;
    end else begin
      for (int i = 0; i < FRAME_BYTES; i++) win[i] <= win_next[i];
      fill <= fill_next;
      sum <= sum_next;
      if (take) fr_valid <= cmd || hit;
      else if (fr_ready) fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr.clr <= cmd;
      fr.ia  <= {win_next[3], win_next[2], win_next[1]};
      fr.iv  <= {win_next[6], win_next[5], win_next[4]};
      fr.pw  <= {win_next[12], win_next[11], win_next[10]};
      fr.cnt <= {win_next[15], win_next[14], win_next[13]};
    end
  end
endmodule

// ===== rtl/emfd_fifo.sv =====
// Short queue between front and back ends.
module emfd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  emfd_pkg::frame_t wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output emfd_pkg::frame_t rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  emfd_pkg::frame_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic wr, rd;

  assign wr_ready = cnt != (AW+1)'(DEPTH);
  assign rd_valid = cnt != '0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end
endmodule

// ===== rtl/emfd_back.sv =====
// Back end: scaling multiplies, energy update with reciprocal divide.
module emfd_back #(
  parameter longint GAIN_SCALE = 65536,
  parameter longint ENERGY_DIVISOR = 1000000
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       voltage_gain,
  input  logic [31:0]       current_gain,
  input  logic [31:0]       power_gain,
  input  logic              fr_valid,
  output logic              fr_ready,
  input  emfd_pkg::frame_t  fr,
  output logic              res_valid,
  input  logic              res_ready,
  output emfd_pkg::result_t res
);
  localparam longint SCALE = (GAIN_SCALE == 0) ? 1 : GAIN_SCALE;
  localparam longint DIV = (ENERGY_DIVISOR == 0) ? 1 : ENERGY_DIVISOR;
  localparam logic [63:0] DIVW = 64'(DIV);
  // floor(2^60 / divisor); the dividend stays below 2^60, so the quotient
  // estimate is low by at most one
  localparam logic [63:0] RECIP = 64'h1000_0000_0000_0000 / DIVW;
  localparam logic [63:0] HALF = 64'(SCALE / 2);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SCALE, S_EMUL, S_RMUL, S_QMUL, S_FIX, S_OUT
  } st_t;
  st_t st;

  logic [23:0] last_counter;
  logic        baseline_valid;
  logic [31:0] energy_acc, energy_remainder;
  logic [23:0] iv, ia, pw, delta;
  logic        do_energy;
  logic [55:0] pv, pa, pp, pd;   // 24x32 products
  logic [63:0] s, q, r, qd;
  logic [127:0] acc;
  logic [1:0]  step;
  logic [15:0] v16, a16;
  logic [14:0] p15;

  logic [63:0] sv, sa, sp;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [127:0] acc_add;
  logic [63:0] qe, r_est;

  assign sv = 64'(pv) / 64'(SCALE);
  assign sa = 64'(pa) / 64'(SCALE);
  assign sp = (64'(pp) + HALF) / 64'(SCALE);
  assign qe = acc[123:60];
  assign r_est = s - qd;

  // one shared 32x32 multiplier: s * RECIP in four partial products,
  // then the low 64 bits of estimate * divisor in two
  always_comb begin
    if (st == S_QMUL) begin
      mul_a = step[0] ? qe[63:32] : qe[31:0];
      mul_b = DIVW[31:0];
    end else begin
      mul_a = step[1] ? s[63:32] : s[31:0];
      mul_b = step[0] ? RECIP[63:32] : RECIP[31:0];
    end
    mul_p = mul_a * mul_b;
    case (step)
      2'd0: acc_add = {64'd0, mul_p};
      2'd1, 2'd2: acc_add = {32'd0, mul_p, 32'd0};
      default: acc_add = {mul_p, 64'd0};
    endcase
  end

  assign fr_ready = st == S_IDLE && !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      res_valid <= 1'b0;
      last_counter <= '0;
      baseline_valid <= 1'b0;
      energy_acc <= '0;
      energy_remainder <= '0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (st)
        S_IDLE: if (fr_valid && fr_ready) begin
          if (fr.clr) begin
            energy_acc <= '0;
            energy_remainder <= '0;
            baseline_valid <= 1'b0;
          end else begin
            iv <= fr.iv;
            ia <= fr.ia;
            pw <= fr.pw[23] ? 24'(25'h1000000 - 25'(fr.pw)) : fr.pw;
            do_energy <= baseline_valid;
            if (fr.cnt >= last_counter) delta <= fr.cnt - last_counter;
            else if (last_counter >= emfd_pkg::WRAP_HIGH && fr.cnt <= emfd_pkg::WRAP_LOW)
              delta <= fr.cnt - last_counter;
            else delta <= '0;
            baseline_valid <= 1'b1;
            last_counter <= fr.cnt;
            st <= S_MUL;
          end
        end
        S_MUL: begin
          pv <= iv * voltage_gain;
          pa <= ia * current_gain;
          pp <= pw * power_gain;
          pd <= delta * power_gain;
          st <= S_SCALE;
        end
        S_SCALE: begin
          v16 <= (sv > 64'd65535) ? 16'hFFFF : sv[15:0];
          a16 <= (sa > 64'd65535) ? 16'hFFFF : sa[15:0];
          p15 <= (sp > 64'd32767) ? 15'h7FFF : sp[14:0];
          st <= do_energy ? S_EMUL : S_OUT;
        end
        S_EMUL: begin
          s <= 64'(energy_remainder) + {5'd0, pd, 3'd0};
          acc <= '0;
          step <= '0;
          st <= S_RMUL;
        end
        S_RMUL: begin
          acc <= acc + acc_add;
          step <= step + 2'd1;
          if (step == 2'd3) st <= S_QMUL;
        end
        S_QMUL: begin
          if (step == 2'd0) begin
            qd <= mul_p;
            step <= 2'd1;
          end else begin
            qd <= qd + {mul_p[31:0], 32'd0};
            step <= '0;
            st <= S_FIX;
          end
        end
        S_FIX: begin
          if (r_est >= DIVW) begin
            q <= qe + 64'd1;
            r <= r_est - DIVW;
          end else begin
            q <= qe;
            r <= r_est;
          end
          st <= S_OUT;
        end
        S_OUT: begin
          if (do_energy) begin
            if (q >= 64'(32'hFFFFFFFF - energy_acc)) begin
              energy_acc <= 32'hFFFFFFFF;
              energy_remainder <= '0;
            end else begin
              energy_acc <= energy_acc + q[31:0];
              energy_remainder <= r[31:0];
            end
          end
          res_valid <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res.volts = v16;
    res.amps = a16;
    res.watts = p15;
    res.energy_total = energy_acc;
    res.raw_volts = iv;
    res.raw_amps = ia;
    res.raw_watts = pw;
  end

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (rst)
    st != S_IDLE |-> !fr_ready) else $error("accept while busy");
  a_out: assert property (@(posedge clk) disable iff (rst)
    st == S_OUT |=> res_valid) else $error("result not raised");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(energy_acc)) else $error("result lost");
`endif
endmodule

// ===== rtl/energy_meter_frame_decoder_core.sv =====
// Top level: energy meter frame decoder.
// A byte completing a good frame is registered in the front end and queued; the back end runs
// MUL and SCALE, then EMUL, RMUL, QMUL and FIX when energy is updated, then OUT. Throughput:
// one byte per cycle while the queue has room, which absorbs bursts; the back end takes one
// frame at a time, not while a result waits. Clears pass the same queue and give no result.
// Reset (rst, synchronous): empties window, queue, energy state; gains return to 65536.
module energy_meter_frame_decoder_core #(
  parameter int     FRAME_BYTES = 23,
  parameter longint GAIN_SCALE = 65536,
  parameter longint ENERGY_DIVISOR = 1000000
) (
  input  logic        clk,
  input  logic        rst,
  emfd_in_if.sink     in_ch,
  emfd_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic [31:0] voltage_gain, current_gain, power_gain;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_gain <= 32'd65536;
      current_gain <= 32'd65536;
      power_gain <= 32'd65536;
    end else if (cfg_we) begin
      if ({1'b0, cfg_index} == emfd_pkg::REG_VGAIN) voltage_gain <= cfg_data;
      if ({1'b0, cfg_index} == emfd_pkg::REG_IGAIN) current_gain <= cfg_data;
      if ({1'b0, cfg_index} == emfd_pkg::REG_PGAIN) power_gain <= cfg_data;
    end
  end

  logic f_valid, f_ready, q_valid, q_ready;
  emfd_pkg::frame_t f_data, q_data;
  emfd_pkg::result_t res;

  emfd_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .cmd(in_ch.cmd),
    .rx_byte(in_ch.rx_byte), .fr_valid(f_valid), .fr_ready(f_ready), .fr(f_data));

  emfd_fifo #(.DEPTH(4)) u_fifo (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data));

  emfd_back #(.GAIN_SCALE(GAIN_SCALE), .ENERGY_DIVISOR(ENERGY_DIVISOR)) u_back (
    .clk, .rst, .voltage_gain, .current_gain, .power_gain,
    .fr_valid(q_valid), .fr_ready(q_ready), .fr(q_data),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res));

  assign out_ch.volts = res.volts;
  assign out_ch.amps = res.amps;
  assign out_ch.watts = res.watts;
  assign out_ch.energy_total = res.energy_total;
  assign out_ch.raw_volts = res.raw_volts;
  assign out_ch.raw_amps = res.raw_amps;
  assign out_ch.raw_watts = res.raw_watts;
endmodule

// ===== bench/energy_meter_frame_decoder_core_tb.sv =====
// Testbench for the energy meter frame decoder: framed byte stimulus, energy predictor, checks.
`timescale 1ns / 100ps

module energy_meter_frame_decoder_core_tb;

  localparam int WIN_BYTES = 23;
  localparam longint unsigned SCALE = 65536;
  localparam longint unsigned EDIV = 1000000;
  // Extra settling time once all expected readings have arrived.
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_REQUESTS = 1380;
  localparam int LONG_HOLD = 3000;

  // Command codes of the request channel.
  localparam bit CMD_BYTE = 1'b0;
  localparam bit CMD_CLEAR = 1'b1;

  // Scoreboard: tracks the byte window and energy state, queues expected readings.
  class meter_scoreboard;
    bit [7:0] win[WIN_BYTES];
    int fill;
    bit [31:0] gain[3];
    bit [23:0] last_cnt;
    bit base_ok;
    bit [31:0] energy;
    bit [31:0] rem;
    emfd_pkg::result_t readings_q[$];
    int mismatches;
    int frames_seen;
    int results_ok;

    function new();
      foreach (win[i]) win[i] = '0;
      fill = 0;
      foreach (gain[i]) gain[i] = 32'd65536;
      last_cnt = '0;
      base_ok = 0;
      energy = '0;
      rem = '0;
      mismatches = 0;
      frames_seen = 0;
      results_ok = 0;
    endfunction

    function void set_gain(int idx, bit [31:0] val);
      gain[idx] = val;
    endfunction

    function void shift_out();
      for (int i = 0; i < WIN_BYTES - 1; i++) win[i] = win[i + 1];
      fill = WIN_BYTES - 1;
    endfunction

    // Called for every accepted request.
    function void note_request(bit c, bit [7:0] b);
      bit [7:0] sum;
      if (c == CMD_CLEAR) begin
        energy = '0;
        rem = '0;
        base_ok = 0;
        return;
      end
      if (fill >= WIN_BYTES) shift_out();
      win[fill] = b;
      fill++;
      if (fill < WIN_BYTES) return;
      if (win[0] != emfd_pkg::HDR_BYTE) begin
        shift_out();
        return;
      end
      sum = emfd_pkg::SUM_SEED;
      for (int i = 0; i < WIN_BYTES - 1; i++) sum = sum + win[i];
      if ((sum ^ 8'hFF) != win[WIN_BYTES - 1]) begin
        shift_out();
        return;
      end
      decode_frame();
      fill = 0;
    endfunction

    function void decode_frame();
      bit [23:0] ia, iv, pw, cnt, delta;
      bit [24:0] neg;
      longint unsigned v, a, p, s, w;
      emfd_pkg::result_t r;
      ia = {win[3], win[2], win[1]};
      iv = {win[6], win[5], win[4]};
      pw = {win[12], win[11], win[10]};
      cnt = {win[15], win[14], win[13]};
      if (pw[23]) begin
        neg = 25'h1000000 - {1'b0, pw};
        pw = neg[23:0];
      end
      v = longint'(iv) * longint'(gain[emfd_pkg::REG_VGAIN]) / SCALE;
      a = longint'(ia) * longint'(gain[emfd_pkg::REG_IGAIN]) / SCALE;
      p = (longint'(pw) * longint'(gain[emfd_pkg::REG_PGAIN]) + SCALE / 2) / SCALE;
      if (v > 65535) v = 65535;
      if (a > 65535) a = 65535;
      if (p > 32767) p = 32767;
      if (base_ok) begin
        delta = '0;
        if (cnt >= last_cnt) delta = cnt - last_cnt;
        else if (last_cnt >= emfd_pkg::WRAP_HIGH && cnt <= emfd_pkg::WRAP_LOW)
          delta = 24'(25'h1000000 - last_cnt + cnt);
        s = longint'(rem) + longint'(delta) * longint'(gain[emfd_pkg::REG_PGAIN]) * 8;
        w = s / EDIV;
        if (w >= longint'(32'hFFFF_FFFF - energy)) begin
          energy = 32'hFFFF_FFFF;
          rem = '0;
        end else begin
          energy = energy + 32'(w);
          rem = 32'(s % EDIV);
        end
      end else begin
        base_ok = 1;
      end
      last_cnt = cnt;
      r.volts = v[15:0];
      r.amps = a[15:0];
      r.watts = p[14:0];
      r.energy_total = energy;
      r.raw_volts = iv;
      r.raw_amps = ia;
      r.raw_watts = pw;
      readings_q.push_back(r);
      frames_seen++;
    endfunction

    function bit field_ok(string name, longint unsigned e, longint unsigned a);
      if (e == a) return 1;
      if (mismatches < 10) $display("mismatch %s: expected 0x%0h actual 0x%0h", name, e, a);
      return 0;
    endfunction

    function void check_result(emfd_pkg::result_t got);
      emfd_pkg::result_t e;
      bit ok;
      if (readings_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
        return;
      end
      e = readings_q.pop_front();
      ok = field_ok("volts", e.volts, got.volts);
      ok &= field_ok("amps", e.amps, got.amps);
      ok &= field_ok("watts", e.watts, got.watts);
      ok &= field_ok("energy_total", e.energy_total, got.energy_total);
      ok &= field_ok("raw_volts", e.raw_volts, got.raw_volts);
      ok &= field_ok("raw_amps", e.raw_amps, got.raw_amps);
      ok &= field_ok("raw_watts", e.raw_watts, got.raw_watts);
      if (ok) results_ok++;
      else mismatches++;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  emfd_in_if in_ch ();
  emfd_out_if out_ch ();

  energy_meter_frame_decoder_core u_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  meter_scoreboard sb;
  int cycles;
  int sent;           // accepted requests, written by the sender only
  bit quiet;          // sender runs back to back, and the receiver adds no random stalls, when set
  bit [23:0] pulse_cnt;
  int good_frames_sent;
  int clears_sent;

  // Clock and run-time guard.
  initial begin
    clk = 0;
    cycles = 0;
    forever begin
      #6 clk = 1;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d readings pending", cycles,
          sb.readings_q.size());
        $display("CHECK FAILED");
        $finish;
      end
      #6 clk = 0;
    end
  end

  // Receiver: random stalls per result, plus one long hold-off once traffic is flowing
  // so the front queue fills and the block pushes back on the sender.
  initial begin : result_sink
    int stall;
    int hold;
    bit held;
    emfd_pkg::result_t got;
    stall = 0;
    hold = 0;
    held = 0;
    out_ch.ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.volts = out_ch.volts;
        got.amps = out_ch.amps;
        got.watts = out_ch.watts;
        got.energy_total = out_ch.energy_total;
        got.raw_volts = out_ch.raw_volts;
        got.raw_amps = out_ch.raw_amps;
        got.raw_watts = out_ch.raw_watts;
        sb.check_result(got);
        stall = quiet ? 0 : $urandom_range(0, 10);
      end
      if (!held && sent >= 500) begin
        held = 1;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  // One request; valid stays high between back-to-back requests.
  task automatic send_req(bit c, bit [7:0] b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.cmd <= c;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(c, b);
    sent++;
    if (c == CMD_CLEAR) clears_sent++;
  endtask

  // Build and send one frame; bad_mode 1 breaks the checksum, 2 the header.
  task automatic send_frame(bit [23:0] ia, bit [23:0] iv, bit [23:0] pw, bit [23:0] cnt,
                            int bad_mode);
    bit [7:0] fr[WIN_BYTES];
    bit [7:0] sum;
    foreach (fr[i]) fr[i] = 8'($urandom);
    fr[0] = (bad_mode == 2) ? (emfd_pkg::HDR_BYTE ^ 8'($urandom_range(1, 255)))
                            : emfd_pkg::HDR_BYTE;
    {fr[3], fr[2], fr[1]} = ia;
    {fr[6], fr[5], fr[4]} = iv;
    {fr[12], fr[11], fr[10]} = pw;
    {fr[15], fr[14], fr[13]} = cnt;
    sum = emfd_pkg::SUM_SEED;
    for (int i = 0; i < WIN_BYTES - 1; i++) sum = sum + fr[i];
    fr[WIN_BYTES - 1] = sum ^ 8'hFF;
    if (bad_mode == 1) fr[WIN_BYTES - 1] ^= 8'($urandom_range(1, 255));
    if (bad_mode == 0) good_frames_sent++;
    foreach (fr[i]) send_req(CMD_BYTE, fr[i]);
  endtask

  // Next pulse counter value: mostly small steps, sometimes wraps, restarts or jumps.
  function automatic bit [23:0] next_pulse();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) pulse_cnt = pulse_cnt + 24'($urandom_range(0, 4095));
    else if (pick < 70) pulse_cnt = pulse_cnt + 24'($urandom);
    else if (pick < 82) begin
      if (pulse_cnt >= emfd_pkg::WRAP_HIGH) pulse_cnt = 24'($urandom_range(0, 65535));
      else pulse_cnt = emfd_pkg::WRAP_HIGH + 24'($urandom_range(0, 65535));
    end else if (pick < 92) pulse_cnt = 24'($urandom_range(0, pulse_cnt));
    else pulse_cnt = 24'($urandom);
    return pulse_cnt;
  endfunction

  // Random 24-bit field biased toward its extremes.
  function automatic bit [23:0] rand24();
    case ($urandom_range(0, 7))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'h800000;
      3: return 24'($urandom_range(0, 255));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.readings_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(logic [2:0] idx, bit [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx[1:0];
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_gain(idx, val);
  endtask

  task automatic set_gains(bit [31:0] vg, bit [31:0] ig, bit [31:0] pg);
    write_gain(emfd_pkg::REG_VGAIN, vg);
    write_gain(emfd_pkg::REG_IGAIN, ig);
    write_gain(emfd_pkg::REG_PGAIN, pg);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int budget;
    int pick;
    sb = new();
    sent = 0;
    quiet = 0;
    pulse_cnt = '0;
    good_frames_sent = 0;
    clears_sent = 0;
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 0;
    in_ch.cmd = CMD_BYTE;
    in_ch.rx_byte = '0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: first frame sets the baseline only, then field extremes,
    // negative full scale power, plain step, natural wrap, chip restart.
    send_frame(24'h000000, 24'h000000, 24'h000000, 24'h000010, 0);
    send_frame(24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF, 24'h000100, 0);
    send_frame(24'h123456, 24'h654321, 24'h800000, 24'hFF8000, 0);
    send_frame(24'h000001, 24'h000001, 24'hFFFFFF, 24'h000200, 0);   // wrap
    send_frame(24'h000002, 24'h000003, 24'h000001, 24'h000100, 0);   // restart
    // Broken frames and a stray byte ahead of a good frame force resync.
    send_frame(24'h111111, 24'h222222, 24'h000333, 24'h000400, 1);
    send_frame(24'h111111, 24'h222222, 24'h000333, 24'h000400, 2);
    send_req(CMD_BYTE, emfd_pkg::HDR_BYTE);
    send_frame(24'h0ABCDE, 24'h00FFFF, 24'h000444, 24'h000500, 0);
    // Clear restarts energy; next frame is a baseline again.
    send_req(CMD_CLEAR, 8'hA5);
    send_frame(24'h000010, 24'h000020, 24'h000030, 24'h00FFF0, 0);
    send_frame(24'h000010, 24'h000020, 24'h000030, 24'h010000, 0);
    drain();

    // Random phases, each under its own gain setting; extremes included.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_gains(32'd65536, 32'd65536, 32'd65536);
        1: set_gains(32'd1, 32'd1, 32'd1);
        2: set_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: set_gains($urandom, $urandom, $urandom);
        4: set_gains($urandom_range(1, 300000), $urandom_range(1, 300000),
                     $urandom_range(1, 300000));
        default: set_gains($urandom_range(1, 65536), $urandom, $urandom_range(60000, 70000));
      endcase
      budget = sent + RANDOM_REQUESTS / 6;
      while (sent < budget) begin
        if ($urandom_range(0, 19) == 0) quiet = !quiet;
        pick = $urandom_range(0, 99);
        if (pick < 78) send_frame(rand24(), rand24(), rand24(), next_pulse(), 0);
        else if (pick < 86) send_frame(rand24(), rand24(), rand24(), next_pulse(),
                                       $urandom_range(1, 2));
        else if (pick < 94) begin
          repeat ($urandom_range(1, 5)) send_req(CMD_BYTE, 8'($urandom));
        end else send_req(CMD_CLEAR, 8'($urandom));
      end
      quiet = 0;
      // Sender waits for every outstanding reading before the gains change.
      drain();
    end

    if (sb.readings_q.size() != 0) sb.mismatches++;
    $display("requests %0d, good frames %0d, clears %0d, readings checked %0d",
      sent, good_frames_sent, clears_sent, sb.results_ok + sb.mismatches);
    $display("six gain settings incl. minimum and maximum, wraps, restarts, resyncs");
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
